FILE: rtl/active_expired_priority_scheduler_macros.svh
// Assertion macros for the active/expired priority scheduler.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef ACTIVE_EXPIRED_PRIORITY_SCHEDULER_MACROS_SVH
`define ACTIVE_EXPIRED_PRIORITY_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define AESP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aesp: same-cycle check failed");
`define AESP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aesp: next-cycle check failed");
`else
`define AESP_ASSERT_NOW(label, ante, cons)
`define AESP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/aesp_pkg.sv
// Shared types and constants of the active/expired priority scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aesp_pkg;

    localparam int TASK_W      = 6;
    localparam int MAX_TASKS   = 64;
    localparam int PRIO_W      = 4;
    localparam int LEVEL_OUT_W = 3;
    localparam int CFG_W       = 4;
    localparam int CMP_W       = 6;

    localparam logic [CFG_W-1:0] LEVEL_COUNT_RESET = 4'd4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    typedef struct packed {
        logic accept;
        logic add_go;
        logic pick_go;
        logic link_go;
    } aesp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_pick;
        logic out_free;
    } aesp_status_t;

endpackage

`default_nettype wire

FILE: rtl/aesp_if.sv
// Request and response channel interfaces of the scheduler.
// Depends on aesp_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface aesp_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [aesp_pkg::TASK_W-1:0]  task_id;
    logic [aesp_pkg::PRIO_W-1:0]  static_priority;
    logic                         from_running;

    modport source (output valid, command, task_id, static_priority, from_running,
                    input ready);
    modport sink   (input valid, command, task_id, static_priority, from_running,
                    output ready);
endinterface

interface aesp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              task_valid;
    logic [aesp_pkg::TASK_W-1:0]       task_out;
    logic [aesp_pkg::LEVEL_OUT_W-1:0]  dyn_level;
    logic                              to_expired;
    logic                              banks_swapped;

    modport source (output valid, task_valid, task_out, dyn_level, to_expired,
                    banks_swapped, input ready);
    modport sink   (input valid, task_valid, task_out, dyn_level, to_expired,
                    banks_swapped, output ready);
endinterface

`default_nettype wire

FILE: rtl/aesp_ctrl.sv
// Sequencing state machine of the scheduler.
// Depends on aesp_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module aesp_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  aesp_pkg::aesp_status_t     st,
    output aesp_pkg::aesp_cmd_t        cmd,
    output logic                       take
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_LINK = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        take        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                take       = 1'b1;
                cmd.accept = st.in_valid;
                if (st.in_valid)
                begin
                    state_next = (st.in_pick == aesp_pkg::CMD_PICK) ? S_PICK : S_ADD;
                end
            end
            S_ADD:
            begin
                if (st.out_free)
                begin
                    cmd.add_go = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PICK:
            begin
                if (st.out_free)
                begin
                    cmd.pick_go = 1'b1;
                    state_next  = S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.link_go = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/aesp_dp.sv
// Datapath of the scheduler: per-task tables, queue pointers, bank state, result register.
// Depends on aesp_pkg and the channel interfaces in aesp_if.
`timescale 1ns / 1ps
`default_nettype none

module aesp_dp
#(
    parameter int MAX_LEVELS = 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    aesp_req_if.sink                           task_req,
    aesp_rsp_if.source                         task_rsp,
    input  wire logic                          cfg_we,
    input  wire logic [aesp_pkg::CFG_W-1:0]    cfg_wdata,
    input  aesp_pkg::aesp_cmd_t                cmd,
    input  wire logic                          take,
    output aesp_pkg::aesp_status_t             st
);

    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LCW = $clog2(MAX_LEVELS + 1);
    localparam int TW  = aesp_pkg::TASK_W;
    localparam int CW  = aesp_pkg::CMP_W;

    logic [aesp_pkg::CFG_W-1:0]  level_count_reg;
    logic [1:0][MAX_LEVELS-1:0]  nonempty_reg;
    logic                        active_reg;
    logic                        out_valid_reg;

    logic [TW-1:0]                   id_reg;
    logic [aesp_pkg::PRIO_W-1:0]     sp_reg;
    logic                            run_reg;
    logic [LW-1:0]                   dyn_rd_reg;
    logic [TW-1:0]                   next_rd_reg;
    logic                            link_pend_reg;
    logic                            pbank_reg;
    logic [LW-1:0]                   plvl_reg;

    logic [LW-1:0]  dyn_level_mem [aesp_pkg::MAX_TASKS];
    logic [TW-1:0]  next_link_mem [aesp_pkg::MAX_TASKS];
    logic [TW-1:0]  head_reg      [2][MAX_LEVELS];
    logic [TW-1:0]  tail_reg      [2][MAX_LEVELS];

    logic                              rsp_task_valid_reg;
    logic [TW-1:0]                     rsp_task_reg;
    logic [aesp_pkg::LEVEL_OUT_W-1:0]  rsp_level_reg;
    logic                              rsp_expired_reg;
    logic                              rsp_swapped_reg;

    logic [LCW-1:0]  lc;
    logic [LCW-1:0]  sp_c;
    logic [LW-1:0]   add_lvl;
    logic            add_exp;
    logic            add_bank;
    logic            add_hit;
    logic [LW-1:0]   dm1;
    logic            act_empty;
    logic            pbank;
    logic [MAX_LEVELS-1:0] pbits;
    logic            pfound;
    logic [LW-1:0]   plvl;
    logic [TW-1:0]   phead;
    logic            plast;
    logic            out_free;

    assign out_free     = !out_valid_reg || task_rsp.ready;
    assign st.in_valid  = task_req.valid;
    assign st.in_pick   = task_req.command;
    assign st.out_free  = out_free;
    assign task_req.ready = take;

    assign task_rsp.valid         = out_valid_reg;
    assign task_rsp.task_valid    = rsp_task_valid_reg;
    assign task_rsp.task_out      = rsp_task_reg;
    assign task_rsp.dyn_level     = rsp_level_reg;
    assign task_rsp.to_expired    = rsp_expired_reg;
    assign task_rsp.banks_swapped = rsp_swapped_reg;

    // Level count in use and clamped static priority
    always_comb
    begin
        if (level_count_reg == '0)
        begin
            lc = LCW'(1);
        end
        else if (CW'(level_count_reg) > CW'(MAX_LEVELS))
        begin
            lc = LCW'(MAX_LEVELS);
        end
        else
        begin
            lc = LCW'(level_count_reg);
        end

        if (sp_reg == '0)
        begin
            sp_c = LCW'(1);
        end
        else if (CW'(sp_reg) > CW'(lc))
        begin
            sp_c = lc;
        end
        else
        begin
            sp_c = LCW'(sp_reg);
        end
    end

    // Level and bank of an added task
    always_comb
    begin
        dm1     = dyn_rd_reg - LW'(1);
        add_exp = 1'b0;
        add_lvl = LW'(sp_c - LCW'(1));
        if (run_reg)
        begin
            if (dyn_rd_reg == '0)
            begin
                add_exp = 1'b1;
            end
            else if (CW'(dm1) >= CW'(lc))
            begin
                add_lvl = LW'(lc - LCW'(1));
            end
            else
            begin
                add_lvl = dm1;
            end
        end
        add_bank = active_reg ^ add_exp;
        add_hit  = nonempty_reg[add_bank][add_lvl];
    end

    // Bank swap and highest non-empty level for a pick
    always_comb
    begin
        act_empty = ~|nonempty_reg[active_reg];
        pbank     = active_reg ^ act_empty;
        pbits     = nonempty_reg[pbank];
        pfound    = |pbits;
        plvl      = '0;
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            if (pbits[l])
            begin
                plvl = LW'(l);
            end
        end
        phead = head_reg[pbank][plvl];
        plast = (phead == tail_reg[pbank][plvl]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= aesp_pkg::LEVEL_COUNT_RESET;
            nonempty_reg    <= '0;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                level_count_reg <= cfg_wdata;
            end
            if (cmd.add_go && !add_hit)
            begin
                nonempty_reg[add_bank][add_lvl] <= 1'b1;
            end
            if (cmd.pick_go)
            begin
                if (act_empty)
                begin
                    active_reg <= ~active_reg;
                end
                if (pfound && plast)
                begin
                    nonempty_reg[pbank][plvl] <= 1'b0;
                end
            end
            if (cmd.add_go || cmd.pick_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (task_rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request beat capture and per-task level read
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg     <= task_req.task_id;
            sp_reg     <= task_req.static_priority;
            run_reg    <= task_req.from_running;
            dyn_rd_reg <= dyn_level_mem[task_req.task_id];
        end
        if (cmd.add_go)
        begin
            dyn_level_mem[id_reg] <= add_lvl;
        end
    end

    // Link table: append on add, follow head on pick
    always_ff @(posedge clk)
    begin
        if (cmd.add_go && add_hit)
        begin
            next_link_mem[tail_reg[add_bank][add_lvl]] <= id_reg;
        end
        if (cmd.pick_go)
        begin
            next_rd_reg   <= next_link_mem[phead];
            link_pend_reg <= pfound && !plast;
            pbank_reg     <= pbank;
            plvl_reg      <= plvl;
        end
    end

    // Queue head and tail pointers
    always_ff @(posedge clk)
    begin
        if (cmd.add_go)
        begin
            tail_reg[add_bank][add_lvl] <= id_reg;
            if (!add_hit)
            begin
                head_reg[add_bank][add_lvl] <= id_reg;
            end
        end
        if (cmd.link_go && link_pend_reg)
        begin
            head_reg[pbank_reg][plvl_reg] <= next_rd_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.add_go)
        begin
            rsp_task_valid_reg <= 1'b1;
            rsp_task_reg       <= id_reg;
            rsp_level_reg      <= aesp_pkg::LEVEL_OUT_W'(add_lvl);
            rsp_expired_reg    <= add_exp;
            rsp_swapped_reg    <= 1'b0;
        end
        else if (cmd.pick_go)
        begin
            rsp_task_valid_reg <= pfound;
            rsp_task_reg       <= pfound ? phead : '0;
            rsp_level_reg      <= pfound ? aesp_pkg::LEVEL_OUT_W'(plvl) : '0;
            rsp_expired_reg    <= 1'b0;
            rsp_swapped_reg    <= act_empty;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/active_expired_priority_scheduler.sv
// Top level of the active/expired multilevel priority scheduler.
// Depends on aesp_pkg, aesp_if, aesp_ctrl, aesp_dp and the assertion macro header.
//
// One request beat is taken at a time. The result register loads in the add or pick state that
// follows acceptance, once the per-task level table has been read. After an add loads, the
// controller returns to idle to accept the next beat. A pick passes through a further link
// state, following the link table to advance the queue head, before returning to idle. While
// the previous result still waits in the result register (ready low on the response side),
// the add or pick holds before loading. Tables need no clearing after reset; the user must
// change level_count only between beats, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
`include "active_expired_priority_scheduler_macros.svh"

module active_expired_priority_scheduler
#(
    parameter int MAX_LEVELS = 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    aesp_req_if.sink                         task_req,
    aesp_rsp_if.source                       task_rsp,
    input  wire logic                        cfg_we,
    input  wire logic [aesp_pkg::CFG_W-1:0]  cfg_wdata
);

    aesp_pkg::aesp_cmd_t     cmd;
    aesp_pkg::aesp_status_t  st;
    logic                    take;

    aesp_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd),
        .take  (take)
    );

    aesp_dp
    #(
        .MAX_LEVELS (MAX_LEVELS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_req  (task_req),
        .task_rsp  (task_rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .take      (take),
        .st        (st)
    );

    `AESP_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.accept, cmd.add_go, cmd.pick_go, cmd.link_go}))
    `AESP_ASSERT_NOW(a_load_free, (cmd.add_go || cmd.pick_go), st.out_free)
    `AESP_ASSERT_NEXT(a_busy_after_beat, cmd.accept, !task_req.ready)
    `AESP_ASSERT_NEXT(a_link_after_pick, cmd.pick_go, cmd.link_go)

endmodule

`default_nettype wire
